>>> design/pts_pkg.sv
// Package for the periodic task scheduler: request and status codes,
// the cell operation code and the fixed field widths.
// Depends on nothing; every other file of the block imports it.
package pts_pkg;

  localparam int unsigned IdentW  = 16;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned OutDueW = 32;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 2;

  // Input beat: tdata holds task_ident then task_period; tuser holds req_type.
  localparam int unsigned InDataW  = IdentW + PeriodW;
  // Output beat: tdata holds out_ident then out_due; tuser holds status.
  localparam int unsigned OutDataW = IdentW + OutDueW;

  typedef enum logic [ReqW-1:0] {
    REQ_REGISTER = 2'd0,
    REQ_NEXT     = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_CLEAR
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_INSERT
  } fsm_e;

endpackage

>>> design/periodic_task_scheduler.sv
// Periodic task scheduler: sorted chain of task cells, request decoder and
// output register. Depends on pts_pkg and pts_chain.
//
// Tasks live in a row of CAPACITY cells kept sorted by (due, id, period), so
// the next task to serve always sits in the head cell. A register request
// that finds room and a next request that finds a task each go on to the
// insert state. The cycle of acceptance decodes the request; a next request
// also removes the head and computes its new due time in that cycle. The
// following cycle slides the new or requeued task into its place along the
// whole chain at once. A clear request, the unused request code, a register
// request on a full queue and a next request on an empty queue stay in the
// idle state. The result beat is presented in the cycle after acceptance
// and sits in an output register. A new request is taken only while that
// register is empty or its beat leaves in the same cycle, so a stalled
// result holds off the input. A due time that would exceed 2^DUE_BITS - 1
// is held at that value and reported with the saturated status.
module periodic_task_scheduler #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned DUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] task_ident, [31:16] task_period
  input  logic [pts_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  logic [pts_pkg::ReqW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] out_ident, [47:16] out_due
  output logic [pts_pkg::OutDataW-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [pts_pkg::StatusW-1:0]   m_axis_tuser
);
  import pts_pkg::*;

  localparam int unsigned KeyW = DUE_BITS + IdentW + PeriodW;

  fsm_e state_q, state_d;
  cell_op_e op;

  logic [KeyW-1:0] ins_key_q, ins_key_d;
  logic [KeyW-1:0] head_key, chain_key;
  logic            empty, full;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q, out_data_d;
  status_e              out_stat_q, out_stat_d;

  logic                 accept;
  req_e                 req;
  logic [IdentW-1:0]    in_ident;
  logic [PeriodW-1:0]   in_period;

  logic [DUE_BITS-1:0]  head_due;
  logic [IdentW-1:0]    head_ident;
  logic [PeriodW-1:0]   head_period;
  logic [DUE_BITS:0]    due_sum;
  logic [DUE_BITS-1:0]  next_due;

  assign s_axis_tready = (state_q == FSM_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign req       = req_e'(s_axis_tuser);
  assign in_ident  = s_axis_tdata[IdentW-1:0];
  assign in_period = s_axis_tdata[InDataW-1:IdentW];

  assign head_due    = head_key[KeyW-1 -: DUE_BITS];
  assign head_ident  = head_key[IdentW+PeriodW-1:PeriodW];
  assign head_period = head_key[PeriodW-1:0];

  assign due_sum  = {1'b0, head_due} + (DUE_BITS+1)'(head_period);
  assign next_due = due_sum[DUE_BITS] ? {DUE_BITS{1'b1}} : due_sum[DUE_BITS-1:0];

  always_comb begin
    state_d    = state_q;
    op         = OP_HOLD;
    ins_key_d  = ins_key_q;
    out_data_d = '0;
    out_stat_d = STAT_OK;
    chain_key  = ins_key_q;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_REGISTER: begin
              if (full) begin
                out_stat_d = STAT_FULL;
              end else begin
                ins_key_d = {DUE_BITS'(in_period), in_ident, in_period};
                state_d   = FSM_INSERT;
              end
            end
            REQ_NEXT: begin
              if (empty) begin
                out_stat_d = STAT_EMPTY;
              end else begin
                out_data_d = {OutDueW'(head_due), head_ident};
                if (due_sum[DUE_BITS]) begin
                  out_stat_d = STAT_SAT;
                end
                op        = OP_POP;
                ins_key_d = {next_due, head_ident, head_period};
                state_d   = FSM_INSERT;
              end
            end
            REQ_CLEAR: op = OP_CLEAR;
            default: ;
          endcase
        end
      end
      FSM_INSERT: begin
        op      = OP_INSERT;
        state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  pts_chain #(
    .CAPACITY(CAPACITY),
    .KEY_W   (KeyW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .ins_key_i (chain_key),
    .head_key_o(head_key),
    .empty_o   (empty),
    .full_o    (full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_key_q <= ins_key_d;
    if (accept) begin
      out_data_q <= out_data_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

>>> design/pts_cell.sv
// One cell of the sorted task chain: holds one task key and its valid bit.
// Depends on pts_pkg for the operation code.
module pts_cell #(
  parameter int unsigned KEY_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::cell_op_e op_i,
  input  logic [KEY_W-1:0]  ins_key_i,
  input  logic [KEY_W-1:0]  left_key_i,
  input  logic              left_valid_i,
  input  logic              left_lt_i,
  input  logic [KEY_W-1:0]  right_key_i,
  input  logic              right_valid_i,
  output logic [KEY_W-1:0]  key_o,
  output logic              valid_o,
  output logic              lt_o
);
  import pts_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             valid_q, valid_d;

  // An empty cell counts as later than any key, so the lt flags of the
  // chain form a run of zeros followed by a run of ones.
  assign lt_o = !valid_q || (ins_key_i < key_q);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    unique case (op_i)
      OP_INSERT: begin
        if (lt_o) begin
          key_d   = left_lt_i ? left_key_i : ins_key_i;
          valid_d = valid_q | left_valid_i;
        end
      end
      OP_POP: begin
        key_d   = right_key_i;
        valid_d = right_valid_i;
      end
      OP_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

>>> design/pts_chain.sv
// Row of pts_cell instances kept sorted by key, smallest at the head.
// Depends on pts_pkg and pts_cell.
module pts_chain #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_W    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::cell_op_e op_i,
  input  logic [KEY_W-1:0]  ins_key_i,
  output logic [KEY_W-1:0]  head_key_o,
  output logic              empty_o,
  output logic              full_o
);
  import pts_pkg::*;

  logic [KEY_W-1:0] key_w   [CAPACITY];
  logic             valid_w [CAPACITY];
  logic             lt_w    [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    logic             left_valid, left_lt, right_valid;

    if (i == 0) begin : g_first
      // The head sits behind a virtual full cell that never moves.
      assign left_key   = ins_key_i;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b0;
    end else begin : g_mid
      assign left_key   = key_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_lt    = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = key_w[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = key_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    pts_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op_i),
      .ins_key_i    (ins_key_i),
      .left_key_i   (left_key),
      .left_valid_i (left_valid),
      .left_lt_i    (left_lt),
      .right_key_i  (right_key),
      .right_valid_i(right_valid),
      .key_o        (key_w[i]),
      .valid_o      (valid_w[i]),
      .lt_o         (lt_w[i])
    );
  end

  assign head_key_o = key_w[0];
  assign empty_o    = !valid_w[0];
  assign full_o     = valid_w[CAPACITY-1];

endmodule
